// File: rtl/core/nalt_pkg.sv
// ----------------------------------------------------------------------------
// nalt_pkg
// Shared types and constants of the name to address lookup table.
// ----------------------------------------------------------------------------
package nalt_pkg;

  localparam int NAME_BYTES    = 12;
  localparam int NAME_W        = 8 * NAME_BYTES;
  localparam int DOMAIN_MAX    = 3;
  localparam int DEFAULT_COUNT = 14;
  localparam int IN_TDATA_W    = 112;
  localparam int OUT_TDATA_W   = 16;

  localparam logic [7:0] DOT_CHAR = 8'h2e;

  localparam logic [1:0] OP_LOOKUP = 2'd0;
  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_BAD_LEN  = 2'd1;
  localparam logic [1:0] STATUS_FULL     = 2'd2;

  localparam logic CFG_DOMAIN_CHARS  = 1'b0;
  localparam logic CFG_DOMAIN_LENGTH = 1'b1;

  // Default names, first character in the lowest byte.
  localparam logic [NAME_W-1:0] DEFAULT_NAMES [DEFAULT_COUNT] = '{
    96'h6d662e63626f,
    96'h6d662e737065,
    96'h6d662e627568,
    96'h6d662e73736f746167,
    96'h6d662e6d6f63,
    96'h6d662e6d6163,
    96'h646e672e636e74,
    96'h646e672e6370,
    96'h6d652e63626f,
    96'h6d652e737065,
    96'h6d652e627568,
    96'h6d652e73736f746167,
    96'h6d652e6d6f63,
    96'h6d652e6d6163
  };

  localparam logic [7:0] DEFAULT_ADDRS [DEFAULT_COUNT] = '{
    8'd1, 8'd2, 8'd3, 8'd4, 8'd5, 8'd6, 8'd9, 8'd10,
    8'd17, 8'd18, 8'd19, 8'd20, 8'd21, 8'd22
  };

  typedef struct packed {
    logic              active;
    logic              found;
    logic [3:0]        slen;
    logic [NAME_W-1:0] search;
    logic [7:0]        addr;
  } token_t;

endpackage

// File: rtl/core/nalt_prep.sv
// ----------------------------------------------------------------------------
// nalt_prep
// Builds the search string and its length from a name and the domain.
// ----------------------------------------------------------------------------
module nalt_prep (
  input  logic [nalt_pkg::NAME_W-1:0] name,
  input  logic [3:0]                  name_length,
  input  logic [23:0]                 domain_chars,
  input  logic [1:0]                  domain_length,
  output logic [nalt_pkg::NAME_W-1:0] search,
  output logic [4:0]                  slen
);
  import nalt_pkg::*;

  logic       has_dot;
  logic       append;
  logic [4:0] len5;
  logic [4:0] dom_end;

  assign len5    = {1'b0, name_length};
  assign dom_end = len5 + {3'b0, domain_length};

  always_comb begin
    has_dot = 1'b0;
    for (int k = 0; k < NAME_BYTES; k++) begin
      if (5'(k) < len5 && name[8*k +: 8] == DOT_CHAR) begin
        has_dot = 1'b1;
      end
    end
  end

  assign append = !has_dot && (domain_length != 2'd0);
  assign slen   = append ? dom_end + 5'd1 : len5;

  always_comb begin
    for (int k = 0; k < NAME_BYTES; k++) begin
      if (5'(k) < len5) begin
        search[8*k +: 8] = name[8*k +: 8];
      end else if (append && 5'(k) == len5) begin
        search[8*k +: 8] = DOT_CHAR;
      end else if (append && 5'(k) <= dom_end) begin
        case (5'(k) - len5)
          5'd1:    search[8*k +: 8] = domain_chars[7:0];
          5'd2:    search[8*k +: 8] = domain_chars[15:8];
          default: search[8*k +: 8] = domain_chars[23:16];
        endcase
      end else begin
        search[8*k +: 8] = 8'd0;
      end
    end
  end

endmodule

// File: rtl/core/nalt_cell.sv
// ----------------------------------------------------------------------------
// nalt_cell
// One table entry; compares the passing search request and forwards it.
// ----------------------------------------------------------------------------
module nalt_cell #(
  parameter int INDEX   = 0,
  parameter int COUNT_W = 6
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [COUNT_W-1:0]          count,
  input  logic                        wr_req,
  input  logic [nalt_pkg::NAME_W-1:0] wr_name,
  input  logic [7:0]                  wr_addr,
  input  nalt_pkg::token_t            tok_in,
  output nalt_pkg::token_t            tok_out
);
  import nalt_pkg::*;

  localparam logic [NAME_W-1:0] RST_NAME =
    (INDEX < DEFAULT_COUNT) ? DEFAULT_NAMES[INDEX % DEFAULT_COUNT] : '0;
  localparam logic [7:0] RST_ADDR =
    (INDEX < DEFAULT_COUNT) ? DEFAULT_ADDRS[INDEX % DEFAULT_COUNT] : 8'd0;

  logic [NAME_W-1:0] entry_name;
  logic [7:0]        entry_addr;
  logic              in_use;
  logic              hit;

  assign in_use = COUNT_W'(INDEX) < count;

  // An entry is rejected at the first differing byte inside the search
  // length, unless an equal zero byte came before it.
  always_comb begin
    logic prefix_ok;
    logic reject;
    prefix_ok = 1'b1;
    reject    = 1'b0;
    for (int k = 0; k < NAME_BYTES; k++) begin
      if (4'(k) < tok_in.slen) begin
        if (prefix_ok && entry_name[8*k +: 8] != tok_in.search[8*k +: 8]) begin
          reject = 1'b1;
        end
        prefix_ok = prefix_ok && (entry_name[8*k +: 8] == tok_in.search[8*k +: 8])
                    && (entry_name[8*k +: 8] != 8'd0);
      end
    end
    hit = in_use && !reject;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_name <= RST_NAME;
      entry_addr <= RST_ADDR;
    end else if (wr_req && count == COUNT_W'(INDEX)) begin
      entry_name <= wr_name;
      entry_addr <= wr_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.active <= 1'b0;
    end else begin
      tok_out.active <= tok_in.active;
    end
    tok_out.slen   <= tok_in.slen;
    tok_out.search <= tok_in.search;
    if (tok_in.active && !tok_in.found && hit) begin
      tok_out.found <= 1'b1;
      tok_out.addr  <= entry_addr;
    end else begin
      tok_out.found <= tok_in.found;
      tok_out.addr  <= tok_in.addr;
    end
  end

endmodule

// File: rtl/core/name_to_address_lookup_table.sv
// ----------------------------------------------------------------------------
// name_to_address_lookup_table
// Table of names and node addresses, searched by a request that walks a row
// of entry cells one cell per cycle.
// ----------------------------------------------------------------------------
// A lookup request is registered into the head of the cell row and walks through
// it; its result is registered and then loaded into the output register, and no
// new request is taken until that load. Inserts, clears, errors and over-long
// searches skip the walk through the cell row. Reset loads the fourteen default
// entries and clears both domain registers; there is no clearing pass.
module name_to_address_lookup_table #(
  parameter int TABLE_DEPTH = 32
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // name_low_chars, name_high_chars, name_length, entry_address, zero pad
  input  logic [nalt_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
  // opcode
  input  logic [1:0]                           s_axis_tuser,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // match_found, found_address, status, zero pad
  output logic [nalt_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic                                 cfg_index,
  input  logic [23:0]                          cfg_data
);
  import nalt_pkg::*;

  localparam int COUNT_W = $clog2(TABLE_DEPTH + 1);
  localparam logic [COUNT_W-1:0] RST_COUNT = COUNT_W'(DEFAULT_COUNT);
  localparam logic [COUNT_W-1:0] FULL_COUNT = COUNT_W'(TABLE_DEPTH);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0]         state;
  logic [COUNT_W-1:0] count;
  logic [23:0]        domain_chars;
  logic [1:0]         domain_length;
  logic               res_match;
  logic [7:0]         res_addr;
  logic [1:0]         res_status;
  logic               out_match;
  logic [7:0]         out_addr;
  logic [1:0]         out_status;
  logic               out_valid;
  token_t             head;
  token_t             tok [TABLE_DEPTH];

  logic [NAME_W-1:0]  in_name;
  logic [NAME_W-1:0]  ins_name;
  logic [3:0]         in_length;
  logic [7:0]         in_addr;
  logic [NAME_W-1:0]  search;
  logic [4:0]         slen;
  logic               in_fire;
  logic               bad_len;
  logic               wr_req;
  logic               start_scan;
  logic               load_out;

  assign in_name   = s_axis_tdata[95:0];
  assign in_length = s_axis_tdata[99:96];
  assign in_addr   = s_axis_tdata[107:100];

  // Name bytes beyond the length are stored as zero.
  always_comb begin
    for (int k = 0; k < NAME_BYTES; k++) begin
      ins_name[8*k +: 8] = (4'(k) < in_length) ? in_name[8*k +: 8] : 8'd0;
    end
  end

  assign s_axis_tready = (state == S_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign bad_len       = in_length > 4'd12;
  assign wr_req        = in_fire && s_axis_tuser == OP_INSERT && !bad_len
                         && count < FULL_COUNT;
  assign start_scan    = in_fire && s_axis_tuser == OP_LOOKUP && !bad_len
                         && slen <= 5'd12;
  assign load_out      = (state == S_DONE) && (!out_valid || m_axis_tready);

  assign cfg_ready     = 1'b1;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {5'd0, out_status, out_addr, out_match};

  nalt_prep u_prep (
    .name          (in_name),
    .name_length   (in_length),
    .domain_chars  (domain_chars),
    .domain_length (domain_length),
    .search        (search),
    .slen          (slen)
  );

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    nalt_cell #(
      .INDEX   (i),
      .COUNT_W (COUNT_W)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .count   (count),
      .wr_req  (wr_req),
      .wr_name (ins_name),
      .wr_addr (in_addr),
      .tok_in  ((i == 0) ? head : tok[(i == 0) ? 0 : i - 1]),
      .tok_out (tok[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      domain_chars  <= 24'd0;
      domain_length <= 2'd0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_DOMAIN_CHARS:  domain_chars  <= cfg_data;
        CFG_DOMAIN_LENGTH: domain_length <= cfg_data[1:0];
        default:           ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      count       <= RST_COUNT;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_fire) begin
            state <= S_DONE;
            unique case (s_axis_tuser)
              OP_LOOKUP: begin
                if (start_scan) begin
                  state <= S_SCAN;
                end
              end
              OP_INSERT: begin
                if (wr_req) begin
                  count <= count + COUNT_W'(1);
                end
              end
              OP_CLEAR: count <= '0;
              default:  ;
            endcase
          end
        end
        S_SCAN: begin
          if (tok[TABLE_DEPTH-1].active) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (load_out) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head.active <= 1'b0;
    end else begin
      head.active <= start_scan;
    end
    head.found  <= 1'b0;
    head.addr   <= 8'd0;
    head.slen   <= slen[3:0];
    head.search <= search;
    if (in_fire) begin
      res_match  <= 1'b0;
      res_addr   <= 8'd0;
      res_status <= STATUS_OK;
      if ((s_axis_tuser == OP_LOOKUP || s_axis_tuser == OP_INSERT) && bad_len) begin
        res_status <= STATUS_BAD_LEN;
      end else if (s_axis_tuser == OP_INSERT && count >= FULL_COUNT) begin
        res_status <= STATUS_FULL;
      end
    end else if (state == S_SCAN && tok[TABLE_DEPTH-1].active) begin
      res_match <= tok[TABLE_DEPTH-1].found;
      res_addr  <= tok[TABLE_DEPTH-1].found ? tok[TABLE_DEPTH-1].addr : 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_match  <= res_match;
      out_addr   <= res_addr;
      out_status <= res_status;
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= FULL_COUNT)
    else $error("entry count beyond table depth");

  a_tail_in_scan: assert property (@(posedge clk) disable iff (rst)
    tok[TABLE_DEPTH-1].active |-> state == S_SCAN)
    else $error("search request left the cell row outside a scan");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> state != S_IDLE)
    else $error("block idle right after taking a request");

  a_head_scan: assert property (@(posedge clk) disable iff (rst)
    head.active |-> state == S_SCAN)
    else $error("search started without entering the scan");

endmodule
